/* rtl/dq_pkg.sv */
package dq_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    ModePushBack  = 2'd0,
    ModePopFront  = 2'd1,
    ModePopBack   = 2'd2,
    ModePushFront = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // Per-beat move order broadcast to every cell of the row.
  typedef struct packed {
    logic push_front;  // every cell takes its left neighbor
    logic pop_front;   // every cell takes its right neighbor
    logic push_back;   // the cell just past the back takes the new word
  } cell_ctl_t;

endpackage

/* rtl/dq_cell.sv */
module dq_cell #(
  parameter int unsigned CntW  = 5,
  parameter int unsigned Index = 0
) (
  input  logic                        clk_i,
  input  dq_pkg::cell_ctl_t           ctl_i,
  input  logic [CntW-1:0]             cnt_i,
  input  logic [dq_pkg::WordW-1:0]    left_i,
  input  logic [dq_pkg::WordW-1:0]    right_i,
  input  logic [dq_pkg::WordW-1:0]    value_i,
  output logic [dq_pkg::WordW-1:0]    data_o,
  output logic [dq_pkg::WordW-1:0]    tap_o
);
  import dq_pkg::*;

  localparam logic [CntW-1:0] SlotC = CntW'(Index);
  localparam logic [CntW-1:0] NextC = CntW'(Index + 1);

  logic [WordW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.push_front) begin
      data_d = left_i;
    end else if (ctl_i.pop_front) begin
      data_d = right_i;
    end else if (ctl_i.push_back && (cnt_i == SlotC)) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Drive the word onto the back tap only when this cell holds the back entry.
  assign tap_o  = (cnt_i == NextC) ? data_q : '0;
  assign data_o = data_q;

endmodule

/* rtl/double_ended_queue.sv */
// Double-ended queue of DEPTH signed 32-bit words built as a row of DEPTH
// identical cells. The front entry always sits in cell 0 and the entries are
// packed toward it, so a push or pop at the front shifts every cell one place
// toward its neighbor in the same cycle, while a push at the back writes the
// single cell just past the back and a pop at the back reads the back cell
// through an OR of per-cell taps. Each input beat carries one operation
// (push back, pop front, pop back, push front) and yields exactly one result
// beat: the popped word (zero for pushes and refusals), a status (done,
// refused as full, refused as empty) and the entry count after the step.
// An accepted beat is processed in the cycle it is taken and its result
// appears in the output register on the next cycle; the block takes one
// beat per cycle as long as the result register is empty or being drained
// in the same cycle, so the rate is one item per cycle, set by the single
// output register. Storage words have no reset; only count, valid flag and
// status are cleared; no word outside the occupied window is ever returned.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       mode_i,
  input  logic signed [dq_pkg::WordW-1:0]  value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [dq_pkg::WordW-1:0]  data_o,
  output logic [1:0]                       status_o,
  output logic [$clog2(DEPTH+1)-1:0]       count_o
);
  import dq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] FullC = CntW'(DEPTH);

  // Fill count and result register.
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             out_valid_d, out_valid_q;
  logic [WordW-1:0] data_d, data_q;
  status_e          status_d, status_q;

  logic      accept, is_push, full, empty;
  mode_e     mode;
  cell_ctl_t ctl;

  logic [WordW-1:0] cell_data [DEPTH];
  logic [WordW-1:0] cell_tap  [DEPTH];
  logic [WordW-1:0] back_word;

  assign mode    = mode_e'(mode_i);
  assign full    = (cnt_q == FullC);
  assign empty   = (cnt_q == '0);
  assign is_push = (mode == ModePushBack) || (mode == ModePushFront);

  // Take a new beat whenever the result slot is free or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Broadcast the move order; refused operations leave the row untouched.
  always_comb begin
    ctl            = '0;
    ctl.push_front = accept && (mode == ModePushFront) && !full;
    ctl.push_back  = accept && (mode == ModePushBack) && !full;
    ctl.pop_front  = accept && (mode == ModePopFront) && !empty;
  end

  // The row of cells. Cell 0 takes the pushed word on a front push; the last
  // cell takes zero on a front pop, which lands outside the occupied window.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    dq_cell #(
      .CntW  (CntW),
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .cnt_i   (cnt_q),
      .left_i  (left_w),
      .right_i (right_w),
      .value_i (value_i),
      .data_o  (cell_data[i]),
      .tap_o   (cell_tap[i])
    );
  end

  // Only the back cell drives a nonzero tap, so an OR picks the back word.
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tap[i];
    end
  end

  // Next count and next result.
  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    data_d      = data_q;
    status_d    = status_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      data_d      = '0;
      status_d    = StDone;
      if (is_push) begin
        if (full) begin
          status_d = StFull;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status_d = StEmpty;
        end else begin
          cnt_d  = cnt_q - 1'b1;
          data_d = (mode == ModePopFront) ? cell_data[0] : back_word;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StDone;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  // Hold the count of the last result alongside its word.
  logic [CntW-1:0] count_d, count_q;
  assign count_d = accept ? cnt_d : count_q;

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    count_q <= count_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

endmodule

/* rtl/dq_checker.sv */
module dq_props #(
  parameter int unsigned DEPTH = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [dq_pkg::WordW-1:0]  data_o,
  input logic [1:0]                       status_o,
  input logic [$clog2(DEPTH+1)-1:0]       count_o
);
  import dq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] FullC = CntW'(DEPTH);

  // A count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= FullC))
    else $error("count above capacity");

  // A refused push only happens with the queue full.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StFull)) |-> (count_o == FullC))
    else $error("full refusal with room left");

  // A refused pop only happens with the queue empty and returns zero.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StEmpty)) |-> ((count_o == '0) && (data_o == '0)))
    else $error("empty refusal with entries or nonzero data");

  // A drained result with no new beat taken leaves the output idle.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !(in_valid_i && in_ready_o)) |=> !out_valid_o)
    else $error("result repeated");

  // A result beat follows every accepted input beat.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted beat without result");

endmodule

bind double_ended_queue dq_props #(.DEPTH(DEPTH)) u_dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_o      (data_o),
  .status_o    (status_o),
  .count_o     (count_o)
);
